// ===== rtl/dtq_pkg.sv =====
// shared types and constants of the deadline timer queue
package dtq_pkg;

    localparam int unsigned TIME_W     = 64;
    localparam int unsigned MAX_EXPIRE = 32;
    localparam int unsigned EXP_W      = $clog2(MAX_EXPIRE + 1);

    // request kinds, anything else is a tick
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;

    // result status codes
    localparam logic [2:0] STAT_ADDED     = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_CANCELLED = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_EXPIRED   = 3'd4;
    localparam logic [2:0] STAT_TICK_DONE = 3'd5;

    // one timer entry as held in the table memory
    typedef struct packed {
        logic [TIME_W-1:0] order;
        logic [TIME_W-1:0] ident;
        logic [TIME_W-1:0] deadline;
    } t_entry;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_ID  = 7'b0000010,
        S_CANCEL   = 7'b0000100,
        S_SCAN_MIN = 7'b0001000,
        S_DECIDE   = 7'b0010000,
        S_EXPIRE   = 7'b0100000,
        S_FINAL    = 7'b1000000
    } t_state;

endpackage

// ===== rtl/dtq_ram.sv =====
// generic single-port-write, registered-read ram
module dtq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/deadline_timer_queue_unit.sv =====
// deadline timer queue: top level with table memory and scan sequencer
//
// slave channel takes one request per handshake: tuser is the kind (add,
// cancel, tick), tdata carries now, deadline and timer id. master channel
// gives the results: tuser is the status, tlast marks the final result of
// a request, tdata carries result id, armed flag and delay to earliest
// deadline. timers live in one memory of MAX_TIMERS entries, read one
// entry a cycle; valid bits sit in flip-flops.
// one request is worked on at a time; o_s_tready is high only when idle.
// add: one minimum scan of the table from request to request.
// cancel: an identifier scan (skipped for id zero), then a minimum scan.
// tick: a minimum scan, then for each expiry a fresh minimum scan
// over the memory read port.
// results leave through an output register, so a stalled receiver holds
// the sequencer only when a further result is ready; the next request is
// taken while the final result still waits.
// reset clears valid bits, the identifier counter (to one), the insertion
// counter and the output valid flag; no memory clearing pass is needed.
module deadline_timer_queue_unit
    import dtq_pkg::*;
#(
    parameter int unsigned MAX_TIMERS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [191:0] i_s_tdata,  // now_time, deadline, cancel_id
    input  logic [1:0]   i_s_tuser,  // kind
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,  // result_id, armed, delay_ns, zero pad
    output logic [2:0]   o_m_tuser,  // status
    output logic         o_m_tlast   // last
);

    localparam int unsigned IW = $clog2(MAX_TIMERS);
    localparam int unsigned CW = $clog2(MAX_TIMERS + 1);

    t_state r_state;
    logic [MAX_TIMERS-1:0] r_valid;
    logic [TIME_W-1:0] r_next_ident;
    logic [TIME_W-1:0] n_next_ident;
    logic [TIME_W-1:0] r_seq;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_id;
    logic              r_tick;
    logic [2:0]        r_status;
    logic [TIME_W-1:0] r_rid;
    logic [CW-1:0]     r_addr;
    logic              r_pv;
    logic [IW-1:0]     r_pidx;
    logic              r_hit;
    logic [IW-1:0]     r_slot;
    logic              r_found;
    logic [TIME_W-1:0] r_best_dl;
    logic [TIME_W-1:0] r_best_ord;
    logic [TIME_W-1:0] r_best_id;
    logic [IW-1:0]     r_best_slot;
    logic [EXP_W-1:0]  r_nexp;

    logic              r_out_vld;
    logic [2:0]        r_out_status;
    logic [TIME_W-1:0] r_out_id;
    logic              r_out_armed;
    logic [TIME_W-1:0] r_out_delay;
    logic              r_out_last;

    logic              s_acc;
    logic              out_free;
    logic              out_load;
    logic              full;
    logic [IW-1:0]     free_slot;
    logic [1:0]        in_kind;
    logic [TIME_W-1:0] in_now;
    logic [TIME_W-1:0] in_deadline;
    logic [TIME_W-1:0] in_cancel_id;
    logic              ram_we;
    t_entry            ram_wdata;
    logic              ram_re;
    t_entry            ram_rdata;
    logic              scan_last;
    logic              better;
    logic [TIME_W-1:0] fin_delay;

    assign in_kind      = i_s_tuser;
    assign in_now       = i_s_tdata[63:0];
    assign in_deadline  = i_s_tdata[127:64];
    assign in_cancel_id = i_s_tdata[191:128];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_vld || i_m_tready;
    assign out_load   = ((r_state == S_EXPIRE) || (r_state == S_FINAL)) && out_free;
    assign full       = &r_valid;

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IW'(i);
            end
        end
    end

    always_comb begin
        n_next_ident = r_next_ident + 64'd1;
        if (n_next_ident == '0) begin
            n_next_ident = 64'd1;
        end
    end

    assign ram_we             = s_acc && (in_kind == KIND_ADD) && !full;
    assign ram_wdata.order    = r_seq;
    assign ram_wdata.ident    = r_next_ident;
    assign ram_wdata.deadline = in_deadline;
    assign ram_re             = ((r_state == S_SCAN_ID) || (r_state == S_SCAN_MIN))
                                && (r_addr < CW'(MAX_TIMERS));

    dtq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TIMERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_slot),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign scan_last = r_pv && (r_pidx == IW'(MAX_TIMERS - 1));

    // earlier deadline wins, ties go to the older insertion
    assign better = !r_found || (ram_rdata.deadline < r_best_dl)
                    || ((ram_rdata.deadline == r_best_dl) && (ram_rdata.order < r_best_ord));

    always_comb begin
        fin_delay = '0;
        if (r_found) begin
            fin_delay = (r_best_dl > r_now) ? (r_best_dl - r_now) : 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_next_ident <= 64'd1;
            r_seq        <= '0;
            r_out_vld    <= 1'b0;
            r_pv         <= 1'b0;
            r_nexp       <= '0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_now   <= in_now;
                        r_id    <= in_cancel_id;
                        r_addr  <= '0;
                        r_pv    <= 1'b0;
                        r_found <= 1'b0;
                        r_hit   <= 1'b0;
                        r_nexp  <= '0;
                        r_tick  <= (in_kind != KIND_ADD) && (in_kind != KIND_CANCEL);
                        case (in_kind)
                            KIND_ADD: begin
                                r_state <= S_SCAN_MIN;
                                if (full) begin
                                    r_status <= STAT_FULL;
                                    r_rid    <= '0;
                                end else begin
                                    r_valid[free_slot] <= 1'b1;
                                    r_slot             <= free_slot;
                                    r_status           <= STAT_ADDED;
                                    r_rid              <= r_next_ident;
                                    r_next_ident       <= n_next_ident;
                                    r_seq              <= r_seq + 64'd1;
                                end
                            end
                            KIND_CANCEL: begin
                                r_status <= STAT_NOT_FOUND;
                                r_rid    <= '0;
                                if (in_cancel_id != '0) begin
                                    r_state <= S_SCAN_ID;
                                end else begin
                                    r_state <= S_SCAN_MIN;
                                end
                            end
                            default: begin
                                r_status <= STAT_TICK_DONE;
                                r_rid    <= '0;
                                r_state  <= S_SCAN_MIN;
                            end
                        endcase
                    end
                end
                S_SCAN_ID, S_SCAN_MIN: begin
                    if (r_addr < CW'(MAX_TIMERS)) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    // the last compare happens once the address has run past the end
                    r_pv   <= (r_addr < CW'(MAX_TIMERS));
                    r_pidx <= r_addr[IW-1:0];
                    if (r_pv && r_valid[r_pidx]) begin
                        if (r_state == S_SCAN_ID) begin
                            if (!r_hit && (ram_rdata.ident == r_id)) begin
                                r_hit  <= 1'b1;
                                r_slot <= r_pidx;
                            end
                        end else if (better) begin
                            r_found     <= 1'b1;
                            r_best_dl   <= ram_rdata.deadline;
                            r_best_ord  <= ram_rdata.order;
                            r_best_id   <= ram_rdata.ident;
                            r_best_slot <= r_pidx;
                        end
                    end
                    if (scan_last) begin
                        r_state <= (r_state == S_SCAN_ID) ? S_CANCEL : S_DECIDE;
                    end
                end
                S_CANCEL: begin
                    if (r_hit) begin
                        r_valid[r_slot] <= 1'b0;
                        r_status        <= STAT_CANCELLED;
                        r_rid           <= r_id;
                    end
                    r_addr  <= '0;
                    r_found <= 1'b0;
                    r_state <= S_SCAN_MIN;
                end
                S_DECIDE: begin
                    if (r_tick && r_found && (r_best_dl <= r_now)
                        && (r_nexp < EXP_W'(MAX_EXPIRE))) begin
                        r_state <= S_EXPIRE;
                    end else begin
                        r_state <= S_FINAL;
                    end
                end
                S_EXPIRE: begin
                    if (out_free) begin
                        r_out_status         <= STAT_EXPIRED;
                        r_out_id             <= r_best_id;
                        r_out_armed          <= 1'b0;
                        r_out_delay          <= '0;
                        r_out_last           <= 1'b0;
                        r_valid[r_best_slot] <= 1'b0;
                        r_nexp               <= r_nexp + EXP_W'(1);
                        r_addr               <= '0;
                        r_found              <= 1'b0;
                        r_state              <= S_SCAN_MIN;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_out_status <= r_status;
                        r_out_id     <= r_rid;
                        r_out_armed  <= r_found;
                        r_out_delay  <= fin_delay;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_out_delay, r_out_armed, r_out_id};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    // an expiry is only issued for a found timer that is due
    a_expire_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPIRE) |-> (r_found && (r_best_dl <= r_now)))
        else $error("expiry of a timer that is not due");

    a_expire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nexp <= EXP_W'(MAX_EXPIRE)))
        else $error("too many expiries in one tick");

    // an accepted add into a free table makes its slot valid
    a_add_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_kind == KIND_ADD) && !full) |=> r_valid[r_slot])
        else $error("added timer slot not marked valid");

    // an expired result is never the final one of a request
    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_status == STAT_EXPIRED)) |-> !r_out_last)
        else $error("expired result marked last");

    // a result is loaded only after the previous one left
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> ($stable(r_out_id) && $stable(r_out_status)))
        else $error("held result overwritten");

endmodule

// ===== bench/deadline_timer_queue_unit_tb.sv =====
// testbench of the deadline timer queue: directed request table, then random requests
`timescale 1ns / 1ps

module deadline_timer_queue_unit_tb
    import dtq_pkg::*;
();

    localparam int unsigned TABLE_DEPTH = 32;
    localparam logic [1:0]  KIND_TICK     = 2'd2;
    localparam logic [1:0]  KIND_TICK_ALT = 2'd3;  // decoded as a tick as well
    localparam logic [63:0] ALL_ONES      = '1;
    localparam logic [63:0] ALT_FIVES     = 64'h5555_5555_5555_5555;
    localparam logic [63:0] ALT_AS        = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam int RANDOM_ITEMS     = 260;
    localparam int PHASE_LEN        = 87;
    localparam int HOLD_AT          = 220;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 80;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] ident;
        logic        armed;
        logic [63:0] delay;
        logic        last;
    } t_timer_result;

    typedef struct {
        logic [1:0]    kind;
        logic [63:0]   now_ns;
        logic [63:0]   deadline;
        logic [63:0]   ident;
        bit            fixed;
        t_timer_result outcome;
    } t_request_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [191:0] i_s_tdata;  // now_time, deadline, cancel_id
    logic [1:0]   i_s_tuser;  // kind
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [135:0] o_m_tdata;  // result_id, armed, delay_ns, zero pad
    logic [2:0]   o_m_tuser;  // status
    logic         o_m_tlast;

    deadline_timer_queue_unit #(
        .MAX_TIMERS(TABLE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // timer table as the bench sees it
    logic [63:0]   slot_deadline [TABLE_DEPTH];
    logic [63:0]   slot_ident    [TABLE_DEPTH];
    logic [63:0]   slot_order    [TABLE_DEPTH];
    bit            slot_live     [TABLE_DEPTH];
    logic [63:0]   ident_counter;
    logic [63:0]   insert_counter;

    t_timer_result fresh_results[$];
    t_timer_result awaited_results[$];
    t_request_row  directed_rows[$];

    int failures;
    int accepted_count;
    int sender_idle_pct;
    int receiver_idle_pct;

    logic [63:0] stim_clock;
    int          burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("deadline_timer_queue_unit verification failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int earliest_slot_idx();
        int best;
        best = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_live[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                (slot_deadline[i] == slot_deadline[best] &&
                 slot_order[i] < slot_order[best])))
                best = i;
        end
        return best;
    endfunction

    function automatic t_timer_result closing_result(logic [2:0] status, logic [63:0] ident,
                                                     logic [63:0] now_ns);
        t_timer_result r;
        int s;
        s = earliest_slot_idx();
        r.status = status;
        r.ident  = ident;
        r.armed  = (s >= 0);
        r.delay  = '0;
        r.last   = 1'b1;
        if (s >= 0)
            r.delay = (slot_deadline[s] > now_ns) ? slot_deadline[s] - now_ns : 64'd1;
        return r;
    endfunction

    // applies one request to the bench table and lists the results it causes
    function automatic void predict_timer_results(logic [1:0] kind, logic [63:0] now_ns,
                                                  logic [63:0] dl, logic [63:0] id);
        int slot;
        int n;
        int s;
        slot = -1;
        if (kind == KIND_ADD) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!slot_live[i] && slot < 0)
                    slot = i;
            end
            if (slot < 0) begin
                fresh_results.push_back(closing_result(STAT_FULL, '0, now_ns));
            end else begin
                slot_deadline[slot] = dl;
                slot_ident[slot]    = ident_counter;
                slot_order[slot]    = insert_counter;
                slot_live[slot]     = 1'b1;
                insert_counter      = insert_counter + 64'd1;
                ident_counter       = (ident_counter == ALL_ONES) ? 64'd1 : ident_counter + 64'd1;
                fresh_results.push_back(closing_result(STAT_ADDED, slot_ident[slot], now_ns));
            end
        end else if (kind == KIND_CANCEL) begin
            if (id != 0) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot < 0 && slot_live[i] && slot_ident[i] == id)
                        slot = i;
                end
            end
            if (slot < 0) begin
                fresh_results.push_back(closing_result(STAT_NOT_FOUND, '0, now_ns));
            end else begin
                slot_live[slot] = 1'b0;
                fresh_results.push_back(closing_result(STAT_CANCELLED, id, now_ns));
            end
        end else begin
            n = 0;
            while (n < MAX_EXPIRE) begin
                s = earliest_slot_idx();
                if (s < 0 || slot_deadline[s] > now_ns)
                    break;
                slot_live[s] = 1'b0;
                fresh_results.push_back({STAT_EXPIRED, slot_ident[s], 1'b0, 64'd0, 1'b0});
                n++;
            end
            fresh_results.push_back(closing_result(STAT_TICK_DONE, '0, now_ns));
        end
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [63:0] now_ns,
                           input logic [63:0] dl, input logic [63:0] id, input bit fixed,
                           input logic [2:0] status, input logic [63:0] rid,
                           input logic armed, input logic [63:0] delay);
        t_request_row row;
        row.kind     = kind;
        row.now_ns   = now_ns;
        row.deadline = dl;
        row.ident    = id;
        row.fixed    = fixed;
        row.outcome  = {status, rid, armed, delay, 1'b1};
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [63:0] now_ns,
                                input logic [63:0] dl, input logic [63:0] id,
                                input bit fixed, input t_timer_result outcome);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {id, dl, now_ns};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        fresh_results.delete();
        predict_timer_results(kind, now_ns, dl, id);
        if (fixed)
            awaited_results.push_back(outcome);
        else
            foreach (fresh_results[k])
                awaited_results.push_back(fresh_results[k]);
        accepted_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic issue_random_request();
        logic [1:0]  kind;
        logic [63:0] dl;
        logic [63:0] id;
        int          c;
        int          start;
        c    = $urandom_range(0, 99);
        dl   = rand64();
        id   = rand64();
        kind = KIND_TICK;
        if ($urandom_range(0, 49) == 0)
            stim_clock = rand64();
        else
            stim_clock = stim_clock + $urandom_range(0, 300);
        if (burst_left == 0 && $urandom_range(0, 99) < 3)
            burst_left = TABLE_DEPTH + 2;
        if (burst_left > 0) begin
            // fill the table with far deadlines and run into the full case
            burst_left--;
            kind = KIND_ADD;
            dl   = stim_clock + $urandom_range(5000, 50000);
        end else if (c < 40) begin
            kind = KIND_ADD;
            c    = $urandom_range(0, 99);
            if (c < 75)
                dl = stim_clock + $urandom_range(0, 3000);
            else if (c < 85)
                dl = stim_clock - $urandom_range(0, 500);
            else if (c >= 95)
                dl = $urandom_range(0, 1) ? ALL_ONES : 64'd0;
        end else if (c < 65) begin
            kind = KIND_CANCEL;
            c    = $urandom_range(0, 99);
            if (c < 75) begin
                start = $urandom_range(0, TABLE_DEPTH - 1);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_live[(start + i) % TABLE_DEPTH] && c < 75) begin
                        id = slot_ident[(start + i) % TABLE_DEPTH];
                        c  = 100;
                    end
                end
            end else if (c < 85) begin
                id = 64'd0;
            end else if (c < 95) begin
                id = ident_counter - 64'd1 - $urandom_range(0, 5);
            end
        end else begin
            kind = $urandom_range(0, 1) ? KIND_TICK : KIND_TICK_ALT;
        end
        send_request(kind, stim_clock, dl, id, 1'b0, '0);
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int hold_left;
        bit hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && accepted_count >= HOLD_AT) begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    initial begin
        t_timer_result seen;
        t_timer_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                seen.status = o_m_tuser;
                seen.ident  = o_m_tdata[63:0];
                seen.armed  = o_m_tdata[64];
                seen.delay  = o_m_tdata[128:65];
                seen.last   = o_m_tlast;
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result: status %0d id %h armed %b delay %h last %b",
                                 seen.status, seen.ident, seen.armed, seen.delay, seen.last);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status || seen.ident !== want.ident ||
                        seen.armed !== want.armed || seen.delay !== want.delay ||
                        seen.last !== want.last) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display("mismatch at %0t:", $realtime);
                            $display("  expected status %0d id %h armed %b delay %h last %b",
                                     want.status, want.ident, want.armed, want.delay,
                                     want.last);
                            $display("  actual   status %0d id %h armed %b delay %h last %b",
                                     seen.status, seen.ident, seen.armed, seen.delay,
                                     seen.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = KIND_ADD;
        failures          = 0;
        accepted_count    = 0;
        sender_idle_pct   = 30;
        receiver_idle_pct = 78;
        stim_clock        = 64'd1000;
        burst_left        = 0;
        ident_counter     = 64'd1;
        insert_counter    = 64'd0;
        foreach (slot_live[i])
            slot_live[i] = 1'b0;

        // kind, now, deadline, id, fixed, then status, id, armed, delay when fixed
        add_row(KIND_TICK,     64'd0,    64'd0,    64'd0,    1'b1,
                STAT_TICK_DONE, 64'd0, 1'b0, 64'd0);
        add_row(KIND_CANCEL,   64'd5,    64'd0,    64'd0,    1'b1,
                STAT_NOT_FOUND, 64'd0, 1'b0, 64'd0);
        add_row(KIND_CANCEL,   ALL_ONES, ALL_ONES, ALL_ONES, 1'b1,
                STAT_NOT_FOUND, 64'd0, 1'b0, 64'd0);
        add_row(KIND_TICK_ALT, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1,
                STAT_TICK_DONE, 64'd0, 1'b0, 64'd0);
        add_row(KIND_ADD,      64'd100,  64'd150,  64'd0,    1'b1,
                STAT_ADDED, 64'd1, 1'b1, 64'd50);
        add_row(KIND_ADD,      64'd100,  ALL_ONES, 64'd0,    1'b1,
                STAT_ADDED, 64'd2, 1'b1, 64'd50);
        // deadline already passed
        add_row(KIND_ADD,      64'd200,  64'd0,    64'd0,    1'b1,
                STAT_ADDED, 64'd3, 1'b1, 64'd1);
        // equal deadline, later insertion
        add_row(KIND_ADD,      64'd200,  64'd150,  64'd0,    1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_CANCEL,   64'd200,  64'd0,    64'd2,    1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_CANCEL,   64'd200,  64'd0,    64'd2,    1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_TICK,     64'd150,  64'd0,    64'd0,    1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_ADD,      64'd0,    ALL_ONES, 64'd0,    1'b1,
                STAT_ADDED, 64'd5, 1'b1, ALL_ONES);
        add_row(KIND_ADD,      ALL_ONES, ALL_ONES, 64'd0,    1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_TICK,     ALL_ONES - 64'd1, 64'd0, 64'd0, 1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_TICK_ALT, ALL_ONES, 64'd0,    64'd0,    1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_ADD,      ALT_AS,   ALT_FIVES, ALT_AS,  1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_ADD,      ALT_FIVES, ALT_AS,  ALT_FIVES, 1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_CANCEL,   ALT_FIVES, ALT_FIVES, 64'h8000_0000_0000_0000,
                1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_TICK,     ALT_FIVES, ALT_AS,  ALT_AS,   1'b0, '0, '0, 1'b0, '0);
        add_row(KIND_CANCEL,   ALT_AS,   64'd0,    64'd8,    1'b0, '0, '0, 1'b0, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].kind, directed_rows[r].now_ns,
                         directed_rows[r].deadline, directed_rows[r].ident,
                         directed_rows[r].fixed, directed_rows[r].outcome);

        burst_left = TABLE_DEPTH + 2;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PHASE_LEN) begin
                wait_all_results();
                sender_idle_pct   = 78;
                receiver_idle_pct = 30;
            end else if (n == 2 * PHASE_LEN) begin
                wait_all_results();
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            issue_random_request();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        failures += awaited_results.size();
        if (failures == 0)
            $display("deadline_timer_queue_unit verification clean");
        else
            $display("deadline_timer_queue_unit verification failed");
        $finish;
    end

endmodule
